FILE: sv/salru_pkg.sv
// types and constants shared by the lru cache miss counter and its testbench
package salru_pkg;

	localparam int ADDR_W     = 32;
	localparam int LINE_SIZE  = 64;
	localparam int NUM_SETS   = 16;
	localparam int NUM_WAYS   = 4;
	localparam int CNT_W      = 32;

	localparam int OFF_W    = $clog2(LINE_SIZE);
	localparam int SET_BITS = $clog2(NUM_SETS);
	localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int TAG_W    = ADDR_W - OFF_W - SET_BITS;
	localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

	typedef logic [SET_W-1:0] set_idx_t;
	typedef logic [TAG_W-1:0] tag_t;
	typedef logic [WAY_W-1:0] way_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic {
		MODE_ACCESS = 1'b0,
		MODE_CLEAR  = 1'b1
	} mode_t;

	// one row of the set memory: tags, valid flags and recency ranks (0 = most recent)
	typedef struct packed {
		logic [NUM_WAYS-1:0][TAG_W-1:0] tag;
		logic [NUM_WAYS-1:0]            valid;
		logic [NUM_WAYS-1:0][WAY_W-1:0] rank;
	} set_entry_t;

	localparam way_t RANK_LAST = way_t'(NUM_WAYS - 1);
	localparam cnt_t CNT_MAX   = '1;

endpackage

FILE: sv/set_assoc_lru_cache_miss_counter.sv
// set-associative true-lru cache model that reports hits and a saturating miss count
//
// A request is taken when start is high and busy is low; the result (hit, miss_total)
// is registered behind act_s1 and appears on the ports with done_q for exactly one cycle,
// marked by done, and the receiver cannot hold it off. The block cannot take a new
// request until the current one is written back: the set's row is read from a single-port
// memory on acceptance and the updated row is written back while busy is high, so busy
// covers that read-modify-write. A clear request empties every set at once through one
// flag per set, so no clearing pass is needed after reset or after a clear.
module set_assoc_lru_cache_miss_counter (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  mode,
	input  logic [31:0]           address,
	output logic                  done,
	output logic                  hit,
	output logic [31:0]           miss_total
);

	salru_pkg::set_entry_t mem [salru_pkg::NUM_SETS];

	logic                  accept;
	salru_pkg::set_idx_t   in_set;
	salru_pkg::tag_t       in_tag;

	logic                  act_s1;
	logic                  mode_s1;
	salru_pkg::set_idx_t   set_s1;
	salru_pkg::tag_t       tag_s1;
	salru_pkg::set_entry_t entry_s1;

	logic [salru_pkg::NUM_SETS-1:0] set_live_q;
	salru_pkg::cnt_t       miss_q;
	logic                  done_q;
	logic                  hit_q;
	salru_pkg::cnt_t       total_q;

	salru_pkg::set_entry_t cur;
	salru_pkg::set_entry_t upd;
	logic                  hit_c;
	salru_pkg::way_t       hit_way;
	salru_pkg::way_t       victim;
	salru_pkg::way_t       touch;
	salru_pkg::way_t       old_rank;
	salru_pkg::cnt_t       miss_nxt;

	assign accept = start && !busy;
	assign busy   = act_s1;
	assign in_set = salru_pkg::set_idx_t'((address >> salru_pkg::OFF_W) &
		32'(salru_pkg::NUM_SETS - 1));
	assign in_tag = salru_pkg::tag_t'(address >> (salru_pkg::OFF_W + salru_pkg::SET_BITS));

	// set memory: read on acceptance, written back in the following cycle for an access
	always_ff @(posedge clk) begin
		if (act_s1 && (mode_s1 == salru_pkg::MODE_ACCESS)) begin
			mem[set_s1] <= upd;
		end
		if (accept) begin
			entry_s1 <= mem[in_set];
			mode_s1  <= mode;
			set_s1   <= in_set;
			tag_s1   <= in_tag;
		end
	end

	// tag compare, victim choice, rank update and the saturating miss count
	always_comb begin
		cur = entry_s1;
		if (!set_live_q[set_s1]) begin
			cur.valid = '0;
			for (int w = 0; w < salru_pkg::NUM_WAYS; w++) begin
				cur.rank[w] = salru_pkg::way_t'(w);
			end
		end
		hit_c   = 1'b0;
		hit_way = '0;
		victim  = '0;
		for (int w = salru_pkg::NUM_WAYS - 1; w >= 0; w--) begin
			if (cur.valid[w] && (cur.tag[w] == tag_s1)) begin
				hit_c   = 1'b1;
				hit_way = salru_pkg::way_t'(w);
			end
			if (cur.rank[w] == salru_pkg::RANK_LAST) begin
				victim = salru_pkg::way_t'(w);
			end
		end
		touch    = hit_c ? hit_way : victim;
		old_rank = cur.rank[touch];
		upd      = cur;
		for (int w = 0; w < salru_pkg::NUM_WAYS; w++) begin
			if (cur.rank[w] < old_rank) begin
				upd.rank[w] = cur.rank[w] + salru_pkg::way_t'(1);
			end
		end
		upd.rank[touch] = '0;
		if (!hit_c) begin
			upd.tag[touch]   = tag_s1;
			upd.valid[touch] = 1'b1;
		end
		miss_nxt = miss_q;
		if (!hit_c && (miss_q != salru_pkg::CNT_MAX)) begin
			miss_nxt = miss_q + salru_pkg::cnt_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1     <= 1'b0;
			done_q     <= 1'b0;
			set_live_q <= '0;
			miss_q     <= '0;
		end else begin
			act_s1 <= accept;
			done_q <= act_s1;
			if (act_s1) begin
				if (mode_s1 == salru_pkg::MODE_CLEAR) begin
					set_live_q <= '0;
					miss_q     <= '0;
				end else begin
					set_live_q[set_s1] <= 1'b1;
					miss_q             <= miss_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act_s1) begin
			if (mode_s1 == salru_pkg::MODE_CLEAR) begin
				hit_q   <= 1'b0;
				total_q <= '0;
			end else begin
				hit_q   <= hit_c;
				total_q <= miss_nxt;
			end
		end
	end

	assign done       = done_q;
	assign hit        = hit_q;
	assign miss_total = total_q;

endmodule

FILE: sv/salru_chk.sv
// port-level checker for the lru cache miss counter, bound to every instance of it
module salru_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        hit,
	input logic [31:0] miss_total
);

	// a taken request keeps the block busy for the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after request");

	// every taken request is answered by done once its busy cycle is over
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("result missing two cycles after request");

	// results never come back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// a hit needs an earlier miss since the last clear
	a_hit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> miss_total != 32'd0)
		else $error("hit reported with zero miss count");

endmodule

bind set_assoc_lru_cache_miss_counter salru_chk u_salru_chk (.*);

FILE: tb/testbench.sv
// self-checking testbench for the lru cache miss counter: directed and random accesses
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		salru_pkg::mode_t mode;
		logic [31:0]      address;
		int unsigned      idle_pct;
	} request_t;

	typedef struct packed {
		logic            hit;
		salru_pkg::cnt_t miss_total;
	} outcome_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	salru_pkg::mode_t mode = salru_pkg::MODE_ACCESS;
	logic [31:0]      address = '0;
	logic             busy;
	logic             done;
	logic             hit;
	logic [31:0]      miss_total;

	request_t access_q[$];
	outcome_t lookup_q[$];
	request_t next_req;
	outcome_t want;
	int       n_queued = 0;
	int       n_taken = 0;
	int       n_errors = 0;
	int       quiet_cycles = 0;

	salru_pkg::tag_t way_tag [salru_pkg::NUM_SETS][salru_pkg::NUM_WAYS];
	logic            way_valid [salru_pkg::NUM_SETS][salru_pkg::NUM_WAYS];
	int unsigned     way_rank [salru_pkg::NUM_SETS][salru_pkg::NUM_WAYS];
	salru_pkg::cnt_t misses;

	set_assoc_lru_cache_miss_counter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.address   (address),
		.done      (done),
		.hit       (hit),
		.miss_total(miss_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void wipe_cache();
		for (int s = 0; s < salru_pkg::NUM_SETS; s++) begin
			for (int w = 0; w < salru_pkg::NUM_WAYS; w++) begin
				way_valid[s][w] = 1'b0;
				way_rank[s][w] = w;
			end
		end
		misses = '0;
	endfunction

	function automatic void make_recent(int s, int w);
		int unsigned old;
		old = way_rank[s][w];
		for (int i = 0; i < salru_pkg::NUM_WAYS; i++) begin
			if (way_rank[s][i] < old)
				way_rank[s][i]++;
		end
		way_rank[s][w] = 0;
	endfunction

	function automatic outcome_t cache_lookup(salru_pkg::mode_t m, logic [31:0] a);
		outcome_t        o;
		int              s;
		salru_pkg::tag_t t;
		int              found;
		int              victim;
		o = '0;
		if (m == salru_pkg::MODE_CLEAR) begin
			wipe_cache();
			return o;
		end
		s = int'(a[salru_pkg::OFF_W +: salru_pkg::SET_W]);
		t = a[salru_pkg::ADDR_W-1 -: salru_pkg::TAG_W];
		found = -1;
		for (int w = 0; w < salru_pkg::NUM_WAYS; w++) begin
			if (found < 0 && way_valid[s][w] && way_tag[s][w] == t)
				found = w;
		end
		if (found >= 0) begin
			o.hit = 1'b1;
			make_recent(s, found);
		end else begin
			if (misses != salru_pkg::CNT_MAX)
				misses++;
			victim = 0;
			for (int w = 0; w < salru_pkg::NUM_WAYS; w++) begin
				if (way_rank[s][w] > way_rank[s][victim])
					victim = w;
			end
			way_tag[s][victim] = t;
			way_valid[s][victim] = 1'b1;
			make_recent(s, victim);
		end
		o.miss_total = misses;
		return o;
	endfunction

	task automatic add_request(salru_pkg::mode_t m, logic [31:0] a, int unsigned pct);
		access_q.push_back('{mode: m, address: a, idle_pct: pct});
		n_queued++;
	endtask

	// address from tag, set and byte offset
	function automatic logic [31:0] line_addr(salru_pkg::tag_t t, int s, int off);
		return {t, s[salru_pkg::SET_W-1:0], off[salru_pkg::OFF_W-1:0]};
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				lookup_q.push_back(cache_lookup(mode, address));
				n_taken++;
			end
			if (!start || !busy) begin
				if (access_q.size() > 0 && $urandom_range(99) >= access_q[0].idle_pct) begin
					next_req = access_q.pop_front();
					mode <= next_req.mode;
					address <= next_req.address;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (lookup_q.size() == 0) begin
				$error("result with no request pending: hit %0d miss_total %0d", hit,
					miss_total);
				n_errors++;
			end else begin
				want = lookup_q.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					n_errors++;
				end
				if (miss_total !== want.miss_total) begin
					$error("miss_total: expected %0d, got %0d", want.miss_total, miss_total);
					n_errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		salru_pkg::tag_t pool [6];
		int              set_a;
		int              set_b;
		int unsigned     pct;
		int unsigned     r;

		wipe_cache();

		// directed: line extremes, hits in the same line, fill and evict in set 0, and clears
		add_request(salru_pkg::MODE_CLEAR, 32'hFFFF_FFFF, 16);
		add_request(salru_pkg::MODE_ACCESS, 32'h0000_0000, 16);
		add_request(salru_pkg::MODE_ACCESS, 32'h0000_0000, 16);
		add_request(salru_pkg::MODE_ACCESS, 32'h0000_003F, 16);
		add_request(salru_pkg::MODE_ACCESS, 32'hFFFF_FFFF, 16);
		add_request(salru_pkg::MODE_ACCESS, 32'hFFFF_FFC0, 16);
		add_request(salru_pkg::MODE_ACCESS, line_addr(salru_pkg::tag_t'(1), 0, 5), 16);
		add_request(salru_pkg::MODE_ACCESS, line_addr(salru_pkg::tag_t'(2), 0, 9), 16);
		add_request(salru_pkg::MODE_ACCESS, line_addr(salru_pkg::tag_t'(3), 0, 63), 16);
		add_request(salru_pkg::MODE_ACCESS, line_addr(salru_pkg::tag_t'(0), 0, 1), 16);
		add_request(salru_pkg::MODE_ACCESS, line_addr(salru_pkg::tag_t'(4), 0, 0), 16);
		add_request(salru_pkg::MODE_ACCESS, line_addr(salru_pkg::tag_t'(1), 0, 0), 16);
		add_request(salru_pkg::MODE_ACCESS, line_addr(salru_pkg::tag_t'(0), 0, 0), 16);
		add_request(salru_pkg::MODE_ACCESS, line_addr(salru_pkg::tag_t'(3), 0, 0), 16);
		add_request(salru_pkg::MODE_ACCESS, line_addr(salru_pkg::tag_t'(2), 0, 0), 16);
		add_request(salru_pkg::MODE_ACCESS, line_addr(salru_pkg::tag_t'(4), 0, 0), 16);
		add_request(salru_pkg::MODE_ACCESS, line_addr('1, 15, 0), 16);
		add_request(salru_pkg::MODE_ACCESS, line_addr('1, 0, 0), 16);
		add_request(salru_pkg::MODE_CLEAR, 32'h0000_0000, 16);
		add_request(salru_pkg::MODE_ACCESS, 32'h0000_0000, 16);
		add_request(salru_pkg::MODE_ACCESS, 32'hFFFF_FFFF, 16);
		add_request(salru_pkg::MODE_ACCESS, 32'hFFFF_FFFF, 16);

		// random: bursts over a small tag pool in two sets, with noise and rare clears
		for (int i = 0; i < 600; i++) begin
			pct = (i < 200) ? 16 : (i < 400) ? 65 : 0;
			if (i % 40 == 0) begin
				foreach (pool[k])
					pool[k] = salru_pkg::tag_t'($urandom());
				set_a = $urandom_range(salru_pkg::NUM_SETS - 1);
				set_b = $urandom_range(salru_pkg::NUM_SETS - 1);
			end
			r = $urandom_range(99);
			if (r < 2)
				add_request(salru_pkg::MODE_CLEAR, $urandom(), pct);
			else if (r < 25)
				add_request(salru_pkg::MODE_ACCESS, $urandom(), pct);
			else
				add_request(salru_pkg::MODE_ACCESS, line_addr(pool[$urandom_range(5)],
					($urandom_range(3) == 0) ? set_b : set_a, $urandom_range(63)), pct);
		end

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait (n_taken == n_queued && lookup_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0 && lookup_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
